>>> design/urm_pkg.sv
// ----------------------------------------------------------------------------
// urm_pkg: shared types and constants for the ultrasonic range meter
// Phase codes, register indexes, channel payloads and reset values.
// ----------------------------------------------------------------------------
package urm_pkg;

  // Default echo counter width
  localparam int COUNT_WIDTH = 16;

  // Register reset values
  localparam logic [7:0]  HALF_PERIOD_RESET = 8'd12;
  localparam logic [7:0]  PULSE_TOTAL_RESET = 8'd8;
  // 0.17 mm/us times the tick period in us, in Q0.16
  localparam logic [15:0] SCALE_RESET       = 16'd12089;

  // Reciprocal of 1000 in Q0.24, rounded down (quotient low by at most one)
  localparam logic [14:0] DIV1000_MUL = 15'd16777;

  // Measurement phase
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_BURST = 2'd1,
    PH_ECHO  = 2'd2
  } phase_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_HALF_PERIOD = 2'd0,
    CFG_PULSE_TOTAL = 2'd1,
    CFG_TIMEOUT     = 2'd2,
    CFG_SCALE       = 2'd3
  } cfg_idx_e;

  // Input item: one timer tick
  typedef struct packed {
    logic command;
    logic rx_level;
  } in_t;

  // Result item
  typedef struct packed {
    logic        tx_level;
    logic        busy_res;
    logic        done_res;
    logic        timed_out;
    logic [15:0] distance_mm;
    logic [3:0]  digit_thousands;
    logic [3:0]  digit_hundreds;
    logic [3:0]  digit_tens;
    logic [3:0]  digit_ones;
  } out_t;

  // Per-tick status carried down the pipeline
  typedef struct packed {
    logic tx_level;
    logic busy;
    logic done;
    logic tmo;
  } flags_t;

  // Load strobes for the digit stages
  typedef struct packed {
    logic ld3;
    logic ld4;
  } pipe_ld_t;

endpackage

>>> design/urm_if.sv
// ----------------------------------------------------------------------------
// urm_if: valid/ready channels of the ultrasonic range meter
// Tick input, result output and configuration write channels.
// ----------------------------------------------------------------------------

// Tick input channel
interface urm_in_if;
  logic         valid;
  logic         ready;
  urm_pkg::in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Result output channel
interface urm_out_if;
  logic          valid;
  logic          ready;
  urm_pkg::out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Configuration write channel
interface urm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [16:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/urm_digits.sv
// ----------------------------------------------------------------------------
// urm_digits: distance saturation and decimal digit split
// Two register stages: thousands by reciprocal multiply, then the low digits.
// ----------------------------------------------------------------------------
module urm_digits #(
  parameter int CountWidth = urm_pkg::COUNT_WIDTH
) (
  input  logic                  clk_i,
  input  urm_pkg::pipe_ld_t     ld_i,
  input  urm_pkg::flags_t       flags_i,
  input  logic [CountWidth+16:0] prod_i,
  output urm_pkg::out_t         result_o
);

  localparam int ProdW = CountWidth + 17;

  // Stage 3: saturate, split off the thousands
  logic [ProdW-1:0] prod_shift;
  logic [15:0]      dist_sat;
  logic [30:0]      k_mul;
  logic [6:0]       k_est;
  logic [16:0]      k_rem_raw;
  logic             k_fix;
  logic [6:0]       k_quo;
  logic [9:0]       k_rem;

  assign prod_shift = prod_i >> 16;
  assign dist_sat   = (prod_shift > ProdW'(16'hFFFF)) ? 16'hFFFF : prod_shift[15:0];
  assign k_mul      = 31'(dist_sat) * 31'(urm_pkg::DIV1000_MUL);
  assign k_est      = k_mul[30:24];
  assign k_rem_raw  = 17'(dist_sat) - 17'(k_est) * 17'(1000);
  // estimate may be one short
  assign k_fix      = (k_rem_raw >= 17'(1000));
  assign k_quo      = k_est + 7'(k_fix);
  assign k_rem      = k_fix ? 10'(k_rem_raw - 17'(1000)) : k_rem_raw[9:0];

  urm_pkg::flags_t flags3_q;
  logic [15:0]     dist3_q;
  logic [6:0]      kquo3_q;
  logic [9:0]      krem3_q;

  always_ff @(posedge clk_i) begin
    if (ld_i.ld3) begin
      flags3_q <= flags_i;
      dist3_q  <= dist_sat;
      kquo3_q  <= k_quo;
      krem3_q  <= k_rem;
    end
  end

  // Stage 4: hundreds, tens, ones; exact reciprocals for these ranges
  logic [15:0] h_mul;
  logic [3:0]  h_dig;
  logic [6:0]  r2;
  logic [14:0] t_mul;
  logic [3:0]  t_dig;
  logic [3:0]  o_dig;
  logic [14:0] kt_mul;
  logic [3:0]  kt;
  logic [3:0]  th_dig;

  assign h_mul  = 16'(krem3_q) * 16'(41);
  assign h_dig  = h_mul[15:12];
  assign r2     = 7'(krem3_q - 10'(h_dig) * 10'(100));
  assign t_mul  = 15'(r2) * 15'(205);
  assign t_dig  = t_mul[14:11];
  assign o_dig  = 4'(r2 - 7'(t_dig) * 7'(10));
  // thousands taken mod 10
  assign kt_mul = 15'(kquo3_q) * 15'(205);
  assign kt     = kt_mul[14:11];
  assign th_dig = 4'(kquo3_q - 7'(kt) * 7'(10));

  urm_pkg::out_t result_q;

  always_ff @(posedge clk_i) begin
    if (ld_i.ld4) begin
      result_q.tx_level        <= flags3_q.tx_level;
      result_q.busy_res        <= flags3_q.busy;
      result_q.done_res        <= flags3_q.done;
      result_q.timed_out       <= flags3_q.tmo;
      result_q.distance_mm     <= dist3_q;
      result_q.digit_thousands <= th_dig;
      result_q.digit_hundreds  <= h_dig;
      result_q.digit_tens      <= t_dig;
      result_q.digit_ones      <= o_dig;
    end
  end

  assign result_o = result_q;

endmodule

>>> design/ultrasonic_range_meter.sv
// ----------------------------------------------------------------------------
// ultrasonic_range_meter: 40 kHz echo ranging controller, one tick per item
// Burst sequencer and echo timer, Q16 scaling and decimal digit pipeline.
// ----------------------------------------------------------------------------
// Each accepted tick's result passes stages 1 to 4 in turn to reach out_o.
// Throughput: one tick per cycle while out_o is ready; the sequencer state
// updates on acceptance and a four-stage elastic pipeline (status, multiply,
// thousands, digits) carries each result, so ticks enter until all four are full.
// Reset: asynchronous; phase idle, counters zero, transmit low, registers
// at their default values, pipeline empty.
module ultrasonic_range_meter #(
  parameter int CountWidth = urm_pkg::COUNT_WIDTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  urm_cfg_if.sink   cfg_i,
  urm_in_if.sink    in_i,
  urm_out_if.source out_o
);

  localparam int CntW   = CountWidth + 1;
  localparam int LimitW = (CntW > 17) ? CntW : 17;
  localparam logic [16:0] TimeoutReset = 17'(33'(1) << CountWidth);

  // Configuration registers
  logic [7:0]  half_period_q;
  logic [7:0]  pulse_total_q;
  logic [16:0] timeout_q;
  logic [15:0] scale_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= urm_pkg::HALF_PERIOD_RESET;
      pulse_total_q <= urm_pkg::PULSE_TOTAL_RESET;
      timeout_q     <= TimeoutReset;
      scale_q       <= urm_pkg::SCALE_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        urm_pkg::CFG_HALF_PERIOD: half_period_q <= cfg_i.data[7:0];
        urm_pkg::CFG_PULSE_TOTAL: pulse_total_q <= cfg_i.data[7:0];
        urm_pkg::CFG_TIMEOUT:     timeout_q     <= cfg_i.data;
        urm_pkg::CFG_SCALE:       scale_q       <= cfg_i.data[15:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake: each stage frees when empty or when it moves on
  logic v1_q, v2_q, v3_q, v4_q;
  logic free1, free2, free3, free4;
  logic move2, move3, move4;
  logic in_fire;

  always_comb begin
    free4 = !v4_q || out_o.ready;
    move4 = v3_q && free4;
    free3 = !v3_q || move4;
    move3 = v2_q && free3;
    free2 = !v2_q || move3;
    move2 = v1_q && free2;
    free1 = !v1_q || move2;
  end

  assign in_i.ready = free1;
  assign in_fire    = in_i.valid && free1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= in_fire || (v1_q && !move2);
      v2_q <= move2   || (v2_q && !move3);
      v3_q <= move3   || (v3_q && !move4);
      v4_q <= move4   || (v4_q && !(v4_q && out_o.ready));
    end
  end

  // Effective register values
  logic [7:0]        eff_half;
  logic [7:0]        eff_pulses;
  logic [LimitW-1:0] tmo_eff;
  logic [LimitW-1:0] cap;
  logic [LimitW-1:0] limit;

  assign eff_half   = (half_period_q == 8'd0) ? 8'd1 : half_period_q;
  assign eff_pulses = (pulse_total_q == 8'd0) ? 8'd1 : pulse_total_q;
  assign tmo_eff    = (timeout_q == 17'd0) ? LimitW'(1) : LimitW'(timeout_q);
  assign cap        = LimitW'(1) << CountWidth;
  assign limit      = (tmo_eff > cap) ? cap : tmo_eff;

  // Sequencer state
  urm_pkg::phase_e phase_q, phase_d;
  logic [7:0]      pulses_q, pulses_d;
  logic [7:0]      half_q, half_d;
  logic [CntW-1:0] echo_q, echo_d;
  logic            tx_q, tx_d;

  logic [CntW-1:0] echo_inc;
  logic            at_limit;
  logic [7:0]      pulses_dec;

  assign echo_inc   = echo_q + CntW'(1);
  assign at_limit   = (LimitW'(echo_inc) >= limit);
  assign pulses_dec = pulses_q - 8'd1;

  // Next state
  always_comb begin
    phase_d  = phase_q;
    pulses_d = pulses_q;
    half_d   = half_q;
    echo_d   = echo_q;
    tx_d     = tx_q;
    unique case (phase_q)
      urm_pkg::PH_IDLE: begin
        if (in_i.data.command) begin
          pulses_d = eff_pulses;
          tx_d     = 1'b1;
          half_d   = eff_half - 8'd1;
          phase_d  = urm_pkg::PH_BURST;
        end
      end
      urm_pkg::PH_BURST: begin
        if (half_q != 8'd0) begin
          half_d = half_q - 8'd1;
        end else if (tx_q) begin
          tx_d   = 1'b0;
          half_d = eff_half - 8'd1;
        end else begin
          pulses_d = pulses_dec;
          if (pulses_dec == 8'd0) begin
            phase_d = urm_pkg::PH_ECHO;
            echo_d  = '0;
          end else begin
            tx_d   = 1'b1;
            half_d = eff_half - 8'd1;
          end
        end
      end
      urm_pkg::PH_ECHO: begin
        tx_d = 1'b0;
        if (!in_i.data.rx_level) begin
          phase_d = urm_pkg::PH_IDLE;
        end else begin
          echo_d = echo_inc;
          if (at_limit) begin
            phase_d = urm_pkg::PH_IDLE;
          end
        end
      end
      default: begin
        phase_d = urm_pkg::PH_IDLE;
        tx_d    = 1'b0;
      end
    endcase
  end

  // Per-tick outputs of the sequencer
  logic done_c, tmo_c;

  always_comb begin
    done_c = 1'b0;
    tmo_c  = 1'b0;
    unique case (phase_q)
      urm_pkg::PH_ECHO: begin
        done_c = !in_i.data.rx_level || at_limit;
        tmo_c  = in_i.data.rx_level && at_limit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= urm_pkg::PH_IDLE;
      pulses_q <= '0;
      half_q   <= '0;
      echo_q   <= '0;
      tx_q     <= 1'b0;
    end else if (in_fire) begin
      phase_q  <= phase_d;
      pulses_q <= pulses_d;
      half_q   <= half_d;
      echo_q   <= echo_d;
      tx_q     <= tx_d;
    end
  end

  // Stage 1: status and the count to scale (zero unless a real echo)
  urm_pkg::flags_t s1_flags_q;
  logic [CntW-1:0] s1_count_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_flags_q.tx_level <= tx_d;
      s1_flags_q.busy     <= (phase_d != urm_pkg::PH_IDLE);
      s1_flags_q.done     <= done_c;
      s1_flags_q.tmo      <= tmo_c;
      s1_count_q          <= (done_c && !tmo_c) ? echo_q : '0;
    end
  end

  // Stage 2: Q16 scale multiply
  urm_pkg::flags_t       s2_flags_q;
  logic [CountWidth+16:0] s2_prod_q;

  always_ff @(posedge clk_i) begin
    if (move2) begin
      s2_flags_q <= s1_flags_q;
      s2_prod_q  <= (CountWidth+17)'(s1_count_q) * (CountWidth+17)'(scale_q);
    end
  end

  // Stages 3 and 4: digits
  urm_pkg::pipe_ld_t ld;

  assign ld.ld3 = move3;
  assign ld.ld4 = move4;

  urm_digits #(
    .CountWidth (CountWidth)
  ) u_digits (
    .clk_i    (clk_i),
    .ld_i     (ld),
    .flags_i  (s2_flags_q),
    .prod_i   (s2_prod_q),
    .result_o (out_o.data)
  );

  assign out_o.valid = v4_q;

  // Checks
  a_echo_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (phase_q == urm_pkg::PH_ECHO) && !in_i.data.rx_level
    |=> v1_q && s1_flags_q.done && !s1_flags_q.tmo)
    else $error("echo fall did not finish a measurement");

  a_echo_tx_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == urm_pkg::PH_ECHO) |-> !tx_q)
    else $error("transmit high during echo timing");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.data.digit_thousands <= 4'd9) &&
                    (out_o.data.digit_hundreds <= 4'd9) &&
                    (out_o.data.digit_tens <= 4'd9) &&
                    (out_o.data.digit_ones <= 4'd9))
    else $error("decimal digit out of range");

endmodule

>>> test/urm_test_pkg.sv
// ----------------------------------------------------------------------------
// urm_test_pkg: result predictor and scoreboard for the range meter test
// Tracks the burst/echo sequencer tick by tick, queues the expected result
// of every accepted tick and compares results from the block field by field.
// ----------------------------------------------------------------------------
package urm_test_pkg;

  // Echo count at which the limit saturates
  localparam logic [16:0] ECHO_CAP = 17'd1 << urm_pkg::COUNT_WIDTH;
  // Mismatch lines printed before further ones are suppressed
  localparam int unsigned MAX_REPORTS = 100;

  class range_scoreboard;
    // Register copies
    logic [7:0]  half_period;
    logic [7:0]  pulse_total;
    logic [16:0] timeout;
    logic [15:0] scale;
    // Sequencer state
    urm_pkg::phase_e phase;
    logic [7:0]  pulses_left;
    logic [7:0]  half_left;
    logic [16:0] echo_count;
    logic        tx;
    // Expected results, oldest first
    urm_pkg::out_t readings[$];
    int unsigned fail_count;
    int unsigned result_count;
    int unsigned done_count;
    int unsigned timeout_count;

    function new();
      half_period   = urm_pkg::HALF_PERIOD_RESET;
      pulse_total   = urm_pkg::PULSE_TOTAL_RESET;
      timeout       = ECHO_CAP;
      scale         = urm_pkg::SCALE_RESET;
      phase         = urm_pkg::PH_IDLE;
      pulses_left   = '0;
      half_left     = '0;
      echo_count    = '0;
      tx            = 1'b0;
      fail_count    = 0;
      result_count  = 0;
      done_count    = 0;
      timeout_count = 0;
    endfunction

    function void write_reg(urm_pkg::cfg_idx_e idx, logic [16:0] value);
      case (idx)
        urm_pkg::CFG_HALF_PERIOD: half_period = value[7:0];
        urm_pkg::CFG_PULSE_TOTAL: pulse_total = value[7:0];
        urm_pkg::CFG_TIMEOUT:     timeout     = value;
        urm_pkg::CFG_SCALE:       scale       = value[15:0];
        default: ;
      endcase
    endfunction

    // Advance the sequencer by one tick and queue the result it produces
    function void note_tick(urm_pkg::in_t tick);
      urm_pkg::out_t r;
      logic [7:0]  half_eff;
      logic [16:0] limit;
      logic [32:0] prod;
      logic [15:0] dist_mm;
      int unsigned d;
      bit          done;
      bit          tmo;
      half_eff = (half_period == 8'd0) ? 8'd1 : half_period;
      if (timeout == 17'd0) begin
        limit = 17'd1;
      end else if (timeout > ECHO_CAP) begin
        limit = ECHO_CAP;
      end else begin
        limit = timeout;
      end
      done    = 1'b0;
      tmo     = 1'b0;
      dist_mm = '0;
      case (phase)
        urm_pkg::PH_IDLE: begin
          // start is taken only when idle
          if (tick.command) begin
            pulses_left = (pulse_total == 8'd0) ? 8'd1 : pulse_total;
            tx          = 1'b1;
            half_left   = half_eff - 8'd1;
            phase       = urm_pkg::PH_BURST;
          end
        end
        urm_pkg::PH_BURST: begin
          if (half_left != 8'd0) begin
            half_left = half_left - 8'd1;
          end else if (tx) begin
            tx        = 1'b0;
            half_left = half_eff - 8'd1;
          end else begin
            pulses_left = pulses_left - 8'd1;
            if (pulses_left == 8'd0) begin
              phase      = urm_pkg::PH_ECHO;
              echo_count = '0;
            end else begin
              tx        = 1'b1;
              half_left = half_eff - 8'd1;
            end
          end
        end
        urm_pkg::PH_ECHO: begin
          if (!tick.rx_level) begin
            prod    = ({16'd0, echo_count} * {17'd0, scale}) >> 16;
            dist_mm = (prod > 33'h0FFFF) ? 16'hFFFF : prod[15:0];
            done    = 1'b1;
            phase   = urm_pkg::PH_IDLE;
          end else begin
            echo_count = echo_count + 17'd1;
            if (echo_count >= limit) begin
              done  = 1'b1;
              tmo   = 1'b1;
              phase = urm_pkg::PH_IDLE;
            end
          end
          tx = 1'b0;
        end
        default: begin
          phase = urm_pkg::PH_IDLE;
          tx    = 1'b0;
        end
      endcase

      r           = '0;
      r.tx_level  = tx;
      r.busy_res  = (phase != urm_pkg::PH_IDLE);
      r.done_res  = done;
      r.timed_out = tmo;
      if (done && !tmo) begin
        d                 = dist_mm;
        r.distance_mm     = dist_mm;
        r.digit_thousands = 4'((d / 1000) % 10);
        r.digit_hundreds  = 4'((d / 100) % 10);
        r.digit_tens      = 4'((d / 10) % 10);
        r.digit_ones      = 4'(d % 10);
      end
      if (done) done_count++;
      if (tmo) timeout_count++;
      readings.push_back(r);
    endfunction

    function int unsigned pending_count();
      return readings.size();
    endfunction

    function void compare(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end else if (fail_count == MAX_REPORTS + 1) begin
          $display("%0t: further mismatches not shown", $time);
        end
      end
    endfunction

    // Compare one result from the block with the oldest expected one
    function void check_result(urm_pkg::out_t got);
      urm_pkg::out_t want;
      result_count++;
      if (readings.size() == 0) begin
        fail_count++;
        $display("%0t: result with nothing expected, actual %h", $time, got);
        return;
      end
      want = readings.pop_front();
      compare("tx_level",        16'(want.tx_level),        16'(got.tx_level));
      compare("busy_res",        16'(want.busy_res),        16'(got.busy_res));
      compare("done_res",        16'(want.done_res),        16'(got.done_res));
      compare("timed_out",       16'(want.timed_out),       16'(got.timed_out));
      compare("distance_mm",     want.distance_mm,          got.distance_mm);
      compare("digit_thousands", 16'(want.digit_thousands), 16'(got.digit_thousands));
      compare("digit_hundreds",  16'(want.digit_hundreds),  16'(got.digit_hundreds));
      compare("digit_tens",      16'(want.digit_tens),      16'(got.digit_tens));
      compare("digit_ones",      16'(want.digit_ones),      16'(got.digit_ones));
    endfunction
  endclass

endpackage

>>> test/ultrasonic_range_meter_test.sv
// ----------------------------------------------------------------------------
// ultrasonic_range_meter_test: self-checking test of the range meter
// Directed measurements at the register extremes and timeout boundaries, then
// random measurement sequences with noise ticks under four sender/receiver
// idling mixes; every result transaction is checked against a tick-level
// predictor.
// ----------------------------------------------------------------------------
module ultrasonic_range_meter_test;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned RANDOM_TICKS   = 700;

  logic clk;
  logic rst_n;

  urm_cfg_if cfg_ch ();
  urm_in_if  tick_ch ();
  urm_out_if result_ch ();

  urm_test_pkg::range_scoreboard board = new();

  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  bit          hold_req;
  int unsigned ticks_sent;
  int unsigned cfg_writes;
  int unsigned quiet_cycles;

  ultrasonic_range_meter i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_ch),
    .in_i  (tick_ch),
    .out_o (result_ch)
  );

  // Clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result side: check accepted results, drive ready with stalls and hold-offs
  initial begin
    int unsigned hold_left;
    hold_left       = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && result_ch.valid && result_ch.ready) begin
        board.check_result(result_ch.data);
      end
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("** ultrasonic_range_meter: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one tick, with random gaps before it, and record it once accepted
  task automatic send_tick(input logic cmd, input logic rx);
    urm_pkg::in_t t;
    t.command  = cmd;
    t.rx_level = rx;
    cfg_ch.valid <= 1'b0;
    while ($urandom_range(99) < send_gap_pct) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.data  <= t;
    do @(posedge clk); while (!tick_ch.ready);
    board.note_tick(t);
    ticks_sent++;
  endtask

  // Finish any measurement in flight; a low echo line ends echo timing at once
  task automatic settle_idle();
    while (board.phase != urm_pkg::PH_IDLE) send_tick(1'b0, 1'b0);
  endtask

  task automatic drain_results();
    tick_ch.valid <= 1'b0;
    while (board.pending_count() != 0) @(posedge clk);
  endtask

  // Register write while the block is idle and all results are out
  task automatic write_reg(input urm_pkg::cfg_idx_e idx, input logic [16:0] value);
    settle_idle();
    drain_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    board.write_reg(idx, value);
    cfg_writes++;
  endtask

  // One measurement: start, burst (with ignored restarts), echo high for
  // echo_len ticks, then low unless the timeout ends it first
  task automatic measure(input int unsigned echo_len, input int unsigned restart_pct);
    int unsigned n;
    settle_idle();
    send_tick(1'b1, 1'($urandom_range(1)));
    while (board.phase == urm_pkg::PH_BURST) begin
      send_tick(1'($urandom_range(99) < restart_pct), 1'($urandom_range(1)));
    end
    n = 0;
    while (board.phase == urm_pkg::PH_ECHO) begin
      send_tick(1'($urandom_range(99) < restart_pct), n < echo_len);
      n++;
    end
  endtask

  // Random register set, mostly short bursts; timeouts mostly at or past the cap
  task automatic pick_settings();
    int unsigned r;
    r = $urandom_range(99);
    write_reg(urm_pkg::CFG_HALF_PERIOD, (r < 10) ? 17'd0 :
              (r < 92) ? 17'($urandom_range(1, 4)) : 17'($urandom_range(5, 20)));
    r = $urandom_range(99);
    write_reg(urm_pkg::CFG_PULSE_TOTAL, (r < 10) ? 17'd0 :
              (r < 92) ? 17'($urandom_range(1, 4)) : 17'($urandom_range(5, 20)));
    r = $urandom_range(99);
    write_reg(urm_pkg::CFG_TIMEOUT, (r < 10) ? 17'd0 : (r < 40) ? 17'($urandom_range(1, 40)) :
              (r < 80) ? urm_test_pkg::ECHO_CAP : 17'($urandom_range(17'h10001, 17'h1FFFF)));
    write_reg(urm_pkg::CFG_SCALE, 17'($urandom_range(16'hFFFF)));
  endtask

  function automatic int unsigned pick_echo_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 85) return $urandom_range(0, 40);
    if (r < 97) return $urandom_range(41, 300);
    return $urandom_range(1000, 1600);
  endfunction

  // Main sequence
  initial begin
    int unsigned budget;
    int unsigned r;
    rst_n          = 1'b0;
    tick_ch.valid  = 1'b0;
    tick_ch.data   = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = urm_pkg::CFG_HALF_PERIOD;
    cfg_ch.data    = '0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    ticks_sent     = 0;
    cfg_writes     = 0;
    quiet_cycles   = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings; a start on every busy tick must be ignored
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    measure(5, 100);

    // Zero half period, pulse count and timeout act as one
    write_reg(urm_pkg::CFG_HALF_PERIOD, 17'd0);
    write_reg(urm_pkg::CFG_PULSE_TOTAL, 17'd0);
    write_reg(urm_pkg::CFG_TIMEOUT, 17'd0);
    write_reg(urm_pkg::CFG_SCALE, 17'hFFFF);
    measure(3, 0);
    // Timeout beyond the counter range; echo on the first echo tick
    write_reg(urm_pkg::CFG_TIMEOUT, 17'h1FFFF);
    measure(0, 0);

    // Longest half period with a single pulse
    write_reg(urm_pkg::CFG_HALF_PERIOD, 17'd255);
    measure(1, 50);
    write_reg(urm_pkg::CFG_HALF_PERIOD, 17'd1);

    // Timeout of one, zero scale, and both sides of a timeout boundary
    write_reg(urm_pkg::CFG_TIMEOUT, 17'd1);
    measure(10, 0);
    write_reg(urm_pkg::CFG_TIMEOUT, 17'd100);
    write_reg(urm_pkg::CFG_SCALE, 17'd0);
    measure(50, 0);
    write_reg(urm_pkg::CFG_SCALE, 17'hFFFF);
    measure(99, 0);
    measure(100, 0);

    // Random measurements under four idling mixes
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 78; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 78; end
        default: begin send_gap_pct = 29; recv_stall_pct = 29; end
      endcase
      pick_settings();
      // long receiver hold-off while ticks keep coming
      if (p == 0 || p == 2) hold_req = 1'b1;
      budget = ticks_sent + RANDOM_TICKS / 4;
      while (ticks_sent < budget) begin
        if ($urandom_range(9) == 0) pick_settings();
        r = $urandom_range(99);
        if (r < 80) begin
          measure(pick_echo_len(), $urandom_range(0, 30));
        end else begin
          // stray ticks; an occasional start leaves a measurement to settle
          repeat ($urandom_range(1, 6)) begin
            send_tick(1'($urandom_range(9) == 0), 1'($urandom_range(1)));
          end
        end
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    $display("Covered %0d ticks and %0d results with %0d register writes,",
             ticks_sent, board.result_count, cfg_writes);
    $display("including %0d finished measurements, %0d of them timed out.",
             board.done_count, board.timeout_count);
    if (board.fail_count == 0 && board.pending_count() == 0) begin
      $display("** ultrasonic_range_meter: PASSED **");
    end else begin
      $display("** ultrasonic_range_meter: FAILED **");
    end
    $finish;
  end

endmodule
